>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, sampled on a clock, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/pde_pkg.sv
// ----------------------------------------------------------------------------
// pde_pkg
// types, register offsets and codes shared by the device enumerator modules
// ----------------------------------------------------------------------------
package pde_pkg;

  localparam int MAX_DEVICES_DEF = 16;
  localparam int NAME_BYTES_DEF  = 32;

  // register offsets in the 4 KiB window
  localparam logic [11:0] OFS_OP        = 12'h000;
  localparam logic [11:0] OFS_NAME_LOW  = 12'h004;
  localparam logic [11:0] OFS_NAME_LEN  = 12'h008;
  localparam logic [11:0] OFS_ID        = 12'h00c;
  localparam logic [11:0] OFS_IO_BASE   = 12'h010;
  localparam logic [11:0] OFS_IO_SIZE   = 12'h014;
  localparam logic [11:0] OFS_IRQ       = 12'h018;
  localparam logic [11:0] OFS_IRQ_COUNT = 12'h01c;
  localparam logic [11:0] OFS_NAME_HIGH = 12'h020;

  // operation register answers
  localparam logic [31:0] CODE_DONE = 32'h0000_0000;
  localparam logic [31:0] CODE_ADD  = 32'h0000_0008;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_NAME  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_WRITE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_MEM   = 2'd1,
    KIND_WDONE = 2'd2,
    KIND_LOAD  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    CMD_ADD,
    CMD_NAME_BYTE,
    CMD_RD_OP,
    CMD_RD_ID,
    CMD_RD_FIELD,
    CMD_RD_BAD,
    CMD_WR_OP,
    CMD_WR_NAME_LOW,
    CMD_WR_NAME_HIGH,
    CMD_WR_BAD
  } cmd_op_t;

  typedef enum logic [2:0] {
    FLD_NAME_LEN,
    FLD_IO_BASE,
    FLD_IO_SIZE,
    FLD_IRQ,
    FLD_IRQ_COUNT
  } field_sel_t;

  // classified request, front to back
  typedef struct packed {
    cmd_op_t     op;
    field_sel_t  fld;
    logic [31:0] data;
    logic [31:0] io_base;
    logic [31:0] io_size;
    logic [31:0] irq;
    logic [31:0] irq_total;
    logic [7:0]  name_byte;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_NAME_LEN,
    BK_NAME_EMIT
  } back_state_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] read_data;
    logic [63:0] mem_address;
    logic [7:0]  mem_byte;
    logic        last;
    logic        irq_level;
    logic        ignored;
  } result_t;

endpackage

>>> hw/rtl/pde_ram.sv
// ----------------------------------------------------------------------------
// pde_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module pde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/pde_front.sv
// ----------------------------------------------------------------------------
// pde_front
// classifies an incoming request into a back-end command
// ----------------------------------------------------------------------------
module pde_front (
  input  logic [1:0]      action,
  input  logic [11:0]     reg_offset,
  input  logic [31:0]     write_data,
  input  logic [31:0]     dev_io_base,
  input  logic [31:0]     dev_io_size,
  input  logic [31:0]     dev_irq,
  input  logic [31:0]     dev_irq_count,
  input  logic [7:0]      name_byte,
  output pde_pkg::cmd_t   cmd
);
  import pde_pkg::*;

  always_comb begin
    cmd           = '0;
    cmd.op        = CMD_WR_BAD;
    cmd.fld       = FLD_NAME_LEN;
    cmd.data      = write_data;
    cmd.io_base   = dev_io_base;
    cmd.io_size   = dev_io_size;
    cmd.irq       = dev_irq;
    cmd.irq_total = dev_irq_count;
    cmd.name_byte = name_byte;
    unique case (action_t'(action))
      ACT_ADD:  cmd.op = CMD_ADD;
      ACT_NAME: cmd.op = CMD_NAME_BYTE;
      ACT_READ: begin
        unique case (reg_offset)
          OFS_OP:        cmd.op = CMD_RD_OP;
          OFS_ID:        cmd.op = CMD_RD_ID;
          OFS_NAME_LEN: begin
            cmd.op  = CMD_RD_FIELD;
            cmd.fld = FLD_NAME_LEN;
          end
          OFS_IO_BASE: begin
            cmd.op  = CMD_RD_FIELD;
            cmd.fld = FLD_IO_BASE;
          end
          OFS_IO_SIZE: begin
            cmd.op  = CMD_RD_FIELD;
            cmd.fld = FLD_IO_SIZE;
          end
          OFS_IRQ: begin
            cmd.op  = CMD_RD_FIELD;
            cmd.fld = FLD_IRQ;
          end
          OFS_IRQ_COUNT: begin
            cmd.op  = CMD_RD_FIELD;
            cmd.fld = FLD_IRQ_COUNT;
          end
          default:       cmd.op = CMD_RD_BAD;
        endcase
      end
      ACT_WRITE: begin
        unique case (reg_offset)
          OFS_OP:        cmd.op = CMD_WR_OP;
          OFS_NAME_LOW:  cmd.op = CMD_WR_NAME_LOW;
          OFS_NAME_HIGH: cmd.op = CMD_WR_NAME_HIGH;
          default:       cmd.op = CMD_WR_BAD;
        endcase
      end
      default: cmd.op = CMD_WR_BAD;
    endcase
  end

endmodule

>>> hw/rtl/pde_cmd_queue.sv
// ----------------------------------------------------------------------------
// pde_cmd_queue
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module pde_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_stall,
  input  pde_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  output pde_pkg::cmd_t pop_cmd,
  input  logic          pop
);
  import pde_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push_fire;
  logic       pop_fire;

  assign push_stall = (count == 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_cmd    = slots[rd_ptr];
  assign push_fire  = push_valid && !push_stall;
  assign pop_fire   = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_fire) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_fire) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push_fire) - 2'(pop_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

>>> hw/rtl/pde_back.sv
// ----------------------------------------------------------------------------
// pde_back
// executes queued commands against the device table, drives the result register
// ----------------------------------------------------------------------------
module pde_back #(
  parameter int MAX_DEVICES = pde_pkg::MAX_DEVICES_DEF,
  parameter int NAME_BYTES  = pde_pkg::NAME_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  pde_pkg::cmd_t    q_cmd,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output pde_pkg::result_t res
);
  import pde_pkg::*;

  localparam int CNTW       = $clog2(MAX_DEVICES + 1);
  localparam int IDXW       = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int LENW       = $clog2(NAME_BYTES);
  localparam int NAME_DEPTH = MAX_DEVICES * NAME_BYTES;
  localparam int NAMEW      = $clog2(NAME_DEPTH);

  back_state_t      state, state_next;
  logic [CNTW-1:0]  entry_count, entry_count_next;
  logic [CNTW-1:0]  next_position, next_position_next;
  logic             sel_valid, sel_valid_next;
  logic [IDXW-1:0]  sel_index, sel_index_next;
  logic [NAMEW-1:0] sel_base, sel_base_next;
  logic [NAMEW-1:0] newest_base, newest_base_next;
  logic [LENW-1:0]  cur_len, cur_len_next;
  logic [31:0]      addr_high, addr_high_next;
  logic [31:0]      addr_low, addr_low_next;
  field_sel_t       cur_fld, cur_fld_next;
  logic [LENW-1:0]  copy_len, copy_len_next;
  logic [LENW-1:0]  name_idx, name_idx_next;

  logic             out_free;
  logic             out_load;
  result_t          res_next;

  logic             fld_we;
  logic [127:0]     fld_rdata;
  logic             len_we;
  logic [IDXW-1:0]  len_waddr;
  logic [LENW-1:0]  len_wdata;
  logic [LENW-1:0]  len_rdata;
  logic             name_we;
  logic [NAMEW-1:0] name_waddr;
  logic [NAMEW-1:0] name_raddr;
  logic [7:0]       name_rdata;

  // io_base, io_size, irq, irq_total packed low to high
  pde_ram #(.WIDTH(128), .DEPTH(MAX_DEVICES)) u_fld_ram (
    .clk   (clk),
    .we    (fld_we),
    .waddr (IDXW'(entry_count)),
    .wdata ({q_cmd.irq_total, q_cmd.irq, q_cmd.io_size, q_cmd.io_base}),
    .raddr (sel_index),
    .rdata (fld_rdata)
  );

  pde_ram #(.WIDTH(LENW), .DEPTH(MAX_DEVICES)) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (len_waddr),
    .wdata (len_wdata),
    .raddr (sel_index),
    .rdata (len_rdata)
  );

  pde_ram #(.WIDTH(8), .DEPTH(NAME_DEPTH)) u_name_ram (
    .clk   (clk),
    .we    (name_we),
    .waddr (name_waddr),
    .wdata (q_cmd.name_byte),
    .raddr (name_raddr),
    .rdata (name_rdata)
  );

  assign out_free   = !out_valid || !out_stall;
  assign name_raddr = sel_base + NAMEW'(name_idx_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= BK_IDLE;
      entry_count   <= '0;
      next_position <= '0;
      sel_valid     <= 1'b0;
      sel_index     <= '0;
      sel_base      <= '0;
      newest_base   <= '0;
      cur_len       <= '0;
      addr_high     <= '0;
      addr_low      <= '0;
      copy_len      <= '0;
      name_idx      <= '0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      entry_count   <= entry_count_next;
      next_position <= next_position_next;
      sel_valid     <= sel_valid_next;
      sel_index     <= sel_index_next;
      sel_base      <= sel_base_next;
      newest_base   <= newest_base_next;
      cur_len       <= cur_len_next;
      addr_high     <= addr_high_next;
      addr_low      <= addr_low_next;
      copy_len      <= copy_len_next;
      name_idx      <= name_idx_next;
      out_valid     <= out_load || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    cur_fld <= cur_fld_next;
    if (out_load) begin
      res <= res_next;
    end
  end

  // sel_valid implies sel_index < entry_count: the table only grows until reset
  always_comb begin
    state_next         = state;
    entry_count_next   = entry_count;
    next_position_next = next_position;
    sel_valid_next     = sel_valid;
    sel_index_next     = sel_index;
    sel_base_next      = sel_base;
    newest_base_next   = newest_base;
    cur_len_next       = cur_len;
    addr_high_next     = addr_high;
    addr_low_next      = addr_low;
    cur_fld_next       = cur_fld;
    copy_len_next      = copy_len;
    name_idx_next      = name_idx;
    q_pop              = 1'b0;
    out_load           = 1'b0;
    res_next           = '0;
    res_next.last      = 1'b1;
    fld_we             = 1'b0;
    len_we             = 1'b0;
    len_waddr          = IDXW'(entry_count);
    len_wdata          = '0;
    name_we            = 1'b0;
    name_waddr         = newest_base + NAMEW'(cur_len);

    unique case (state)
      BK_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          unique case (q_cmd.op)
            CMD_ADD: begin
              out_load      = 1'b1;
              res_next.kind = KIND_LOAD;
              if (entry_count == CNTW'(MAX_DEVICES)) begin
                res_next.ignored = 1'b1;
              end else begin
                fld_we           = 1'b1;
                len_we           = 1'b1;
                len_wdata        = '0;
                newest_base_next = NAMEW'(IDXW'(entry_count) * NAME_BYTES);
                cur_len_next     = '0;
                entry_count_next = entry_count + CNTW'(1);
              end
            end
            CMD_NAME_BYTE: begin
              out_load      = 1'b1;
              res_next.kind = KIND_LOAD;
              if (entry_count == '0 || q_cmd.name_byte == 8'd0 ||
                  cur_len >= LENW'(NAME_BYTES - 1)) begin
                res_next.ignored = 1'b1;
              end else begin
                name_we      = 1'b1;
                len_we       = 1'b1;
                len_waddr    = IDXW'(entry_count - CNTW'(1));
                len_wdata    = cur_len + LENW'(1);
                cur_len_next = cur_len + LENW'(1);
              end
            end
            CMD_RD_OP: begin
              out_load      = 1'b1;
              res_next.kind = KIND_READ;
              if (next_position < entry_count) begin
                sel_valid_next     = 1'b1;
                sel_index_next     = IDXW'(next_position);
                sel_base_next      = NAMEW'(IDXW'(next_position) * NAME_BYTES);
                next_position_next = next_position + CNTW'(1);
                res_next.read_data = CODE_ADD;
              end else begin
                sel_valid_next     = 1'b0;
                sel_index_next     = '0;
                sel_base_next      = '0;
                res_next.read_data = CODE_DONE;
              end
            end
            CMD_RD_ID: begin
              out_load           = 1'b1;
              res_next.kind      = KIND_READ;
              res_next.read_data = sel_valid ? 32'(sel_index) : 32'd0;
            end
            CMD_RD_FIELD: begin
              cur_fld_next = q_cmd.fld;
              state_next   = BK_READ;
            end
            CMD_RD_BAD: begin
              out_load         = 1'b1;
              res_next.kind    = KIND_READ;
              res_next.ignored = 1'b1;
            end
            CMD_WR_OP: begin
              out_load      = 1'b1;
              res_next.kind = KIND_WDONE;
              if (q_cmd.data != 32'd0) begin
                res_next.ignored = 1'b1;
              end else begin
                next_position_next = '0;
                sel_valid_next     = 1'b0;
                sel_index_next     = '0;
                sel_base_next      = '0;
              end
            end
            CMD_WR_NAME_HIGH: begin
              out_load       = 1'b1;
              res_next.kind  = KIND_WDONE;
              addr_high_next = q_cmd.data;
            end
            CMD_WR_NAME_LOW: begin
              if (!sel_valid) begin
                out_load         = 1'b1;
                res_next.kind    = KIND_WDONE;
                res_next.ignored = 1'b1;
              end else begin
                addr_low_next = q_cmd.data;
                state_next    = BK_NAME_LEN;
              end
            end
            default: begin
              out_load         = 1'b1;
              res_next.kind    = KIND_WDONE;
              res_next.ignored = 1'b1;
            end
          endcase
        end
      end

      // ram read data for the selected entry is valid here
      BK_READ: begin
        if (out_free) begin
          out_load      = 1'b1;
          res_next.kind = KIND_READ;
          if (sel_valid) begin
            case (cur_fld)
              FLD_NAME_LEN:  res_next.read_data = 32'(len_rdata);
              FLD_IO_BASE:   res_next.read_data = fld_rdata[31:0];
              FLD_IO_SIZE:   res_next.read_data = fld_rdata[63:32];
              FLD_IRQ:       res_next.read_data = fld_rdata[95:64];
              FLD_IRQ_COUNT: res_next.read_data = fld_rdata[127:96];
              default:       res_next.read_data = 32'd0;
            endcase
          end
          state_next = BK_IDLE;
        end
      end

      BK_NAME_LEN: begin
        name_idx_next = '0;
        if (len_rdata == '0) begin
          if (out_free) begin
            out_load      = 1'b1;
            res_next.kind = KIND_WDONE;
            state_next    = BK_IDLE;
          end
        end else begin
          copy_len_next = len_rdata;
          state_next    = BK_NAME_EMIT;
        end
      end

      // name_rdata holds the byte at name_idx
      BK_NAME_EMIT: begin
        if (out_free) begin
          out_load             = 1'b1;
          res_next.kind        = KIND_MEM;
          res_next.mem_address = {addr_high, addr_low} + 64'(name_idx);
          res_next.mem_byte    = name_rdata;
          res_next.last        = ((LENW+1)'(name_idx) + (LENW+1)'(1)) ==
                                 (LENW+1)'(copy_len);
          if (res_next.last) begin
            state_next = BK_IDLE;
          end else begin
            name_idx_next = name_idx + LENW'(1);
          end
        end
      end

      default: state_next = BK_IDLE;
    endcase

    res_next.irq_level = (next_position_next < entry_count_next);
  end

endmodule

>>> hw/rtl/platform_device_enumerator_core.sv
// ----------------------------------------------------------------------------
// platform_device_enumerator_core
// device descriptor table loaded by add and name-byte requests, walked by a
// driver through a window of 32-bit registers
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall): one request per accepted beat; action
//     picks add entry, append name byte, register read or register write
//   output channel (out_valid / out_stall): result beats; every request gives
//     one beat except a name copy, which gives one beat per name byte, the
//     final beat of a request flagged by last
//   order: a request is written into a two-entry queue when accepted and its
//     first result is then registered; a field read first passes the table
//     ram read, a name copy the length read and then the first byte read
//   throughput: adds, name bytes, operation/id reads and plain writes run one
//     per cycle and a name copy one byte per cycle after the first, all while
//     out_stall is low; a field read holds the executor in a ram read state
//   reset: table empty, no selection, name address words zero, queue empty;
//     table contents are undefined until an add writes them
//   receiver stall: the result register holds, the executor waits, the queue
//     fills and then in_stall rises
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module platform_device_enumerator_core #(
  parameter int MAX_DEVICES = pde_pkg::MAX_DEVICES_DEF,
  parameter int NAME_BYTES  = pde_pkg::NAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [11:0] reg_offset,
  input  logic [31:0] write_data,
  input  logic [31:0] dev_io_base,
  input  logic [31:0] dev_io_size,
  input  logic [31:0] dev_irq,
  input  logic [31:0] dev_irq_count,
  input  logic [7:0]  name_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [31:0] read_data,
  output logic [63:0] mem_address,
  output logic [7:0]  mem_byte,
  output logic        last,
  output logic        irq_level,
  output logic        ignored
);
  import pde_pkg::*;

  cmd_t    front_cmd;   // classified request from the decoder
  cmd_t    q_cmd;       // head of the queue
  logic    q_valid;
  logic    q_pop;
  result_t res;

  // front: classify offset and action into a command
  pde_front u_front (
    .action        (action),
    .reg_offset    (reg_offset),
    .write_data    (write_data),
    .dev_io_base   (dev_io_base),
    .dev_io_size   (dev_io_size),
    .dev_irq       (dev_irq),
    .dev_irq_count (dev_irq_count),
    .name_byte     (name_byte),
    .cmd           (front_cmd)
  );

  // decoupling queue, full queue stalls the request channel
  pde_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_stall (in_stall),
    .push_cmd   (front_cmd),
    .pop_valid  (q_valid),
    .pop_cmd    (q_cmd),
    .pop        (q_pop)
  );

  // back: table state, rams, name copy sequencer and result register
  pde_back #(
    .MAX_DEVICES (MAX_DEVICES),
    .NAME_BYTES  (NAME_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign kind        = res.kind;
  assign read_data   = res.read_data;
  assign mem_address = res.mem_address;
  assign mem_byte    = res.mem_byte;
  assign last        = res.last;
  assign irq_level   = res.irq_level;
  assign ignored     = res.ignored;

  // executor only takes a command that is really there
  `ASSERT_NOW(a_pop_has_cmd, clk, rst, q_pop, q_valid, "pop from empty command queue")

  // a name byte is never a rejected result
  `ASSERT_NOW(a_mem_not_ignored, clk, rst, out_valid && kind == KIND_MEM, !ignored,
    "name byte result flagged as ignored")

  // only register reads carry read data
  `ASSERT_NOW(a_data_only_on_read, clk, rst, out_valid && kind != KIND_READ,
    read_data == 32'd0, "read data on a non-read result")

  // a name copy streams without gaps once a byte is taken
  `ASSERT_NEXT(a_name_stream, clk, rst,
    out_valid && !out_stall && kind == KIND_MEM && !last,
    out_valid && kind == KIND_MEM, "gap in name byte stream")

endmodule

>>> tb/sv/tb_platform_device_enumerator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_platform_device_enumerator_core
// self-checking bench for the device enumerator core: a shadow model of the
// descriptor table and the enumeration walk predicts every result beat, and
// a monitor compares each accepted beat with the oldest prediction. directed
// requests cover the empty table, field extremes and every flagged case;
// random table loads and driver-style walks follow, with random gaps on both
// channels
// ----------------------------------------------------------------------------
module tb_platform_device_enumerator_core;
  import pde_pkg::*;

  localparam int TBL_DEPTH  = MAX_DEVICES_DEF;
  localparam int NAME_SLOTS = NAME_BYTES_DEF;
  localparam int ITEMS      = 460;
  localparam int MAX_WAIT   = 18;
  localparam int REPORT_MAX = 10;

  // one request as the sender sees it, every field random unless overridden
  typedef struct {
    action_t     act;
    logic [11:0] ofs;
    logic [31:0] wdata;
    logic [31:0] io_base;
    logic [31:0] io_size;
    logic [31:0] irq;
    logic [31:0] irq_total;
    logic [7:0]  nbyte;
  } request_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  action;
  logic [11:0] reg_offset;
  logic [31:0] write_data;
  logic [31:0] dev_io_base;
  logic [31:0] dev_io_size;
  logic [31:0] dev_irq;
  logic [31:0] dev_irq_count;
  logic [7:0]  name_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  kind;
  logic [31:0] read_data;
  logic [63:0] mem_address;
  logic [7:0]  mem_byte;
  logic        last;
  logic        irq_level;
  logic        ignored;

  // shadow copy of the table and the walk
  logic [4:0]  tbl_count;
  logic [4:0]  walk_pos;
  logic        sel_valid;
  logic [3:0]  sel_idx;
  logic [31:0] addr_hi;
  logic [31:0] addr_lo;
  logic [31:0] tbl_io_base   [TBL_DEPTH];
  logic [31:0] tbl_io_size   [TBL_DEPTH];
  logic [31:0] tbl_irq       [TBL_DEPTH];
  logic [31:0] tbl_irq_total [TBL_DEPTH];
  logic [4:0]  tbl_name_size [TBL_DEPTH];
  logic [7:0]  tbl_name      [TBL_DEPTH][NAME_SLOTS];

  result_t     pending_q [$];   // predicted beats, oldest first
  int          req_count;
  int          noise_count;
  int          mismatches;
  int          out_hold;        // stall cycles left before the next beat
  bit          burst;           // no gaps on either side while set

  platform_device_enumerator_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .reg_offset   (reg_offset),
    .write_data   (write_data),
    .dev_io_base  (dev_io_base),
    .dev_io_size  (dev_io_size),
    .dev_irq      (dev_irq),
    .dev_irq_count(dev_irq_count),
    .name_byte    (name_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .read_data    (read_data),
    .mem_address  (mem_address),
    .mem_byte     (mem_byte),
    .last         (last),
    .irq_level    (irq_level),
    .ignored      (ignored)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // hard stop well past the slowest legal run
  initial begin
    #(20_000_000);
    $display("tb_platform_device_enumerator_core: done, errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // prediction
  // --------------------------------------------------------------------------

  // irq level is sampled after the request has updated the walk
  function automatic void push_result(kind_t k, logic [31:0] data, logic [63:0] addr,
                                      logic [7:0] b, logic fin, logic flag);
    result_t res;
    res.kind        = k;
    res.read_data   = data;
    res.mem_address = addr;
    res.mem_byte    = b;
    res.last        = fin;
    res.irq_level   = (walk_pos < tbl_count);
    res.ignored     = flag;
    pending_q.push_back(res);
  endfunction

  function automatic void apply_request(request_t r);
    logic        sel;
    logic        flag;
    logic [31:0] val;
    logic [63:0] base;
    logic [4:0]  top;
    int          len;
    kind_t       k;
    sel  = sel_valid && (sel_idx < tbl_count);
    flag = 1'b0;
    val  = 32'd0;
    top  = tbl_count - 5'd1;
    case (r.act)
      ACT_ADD: begin
        k = KIND_LOAD;
        if (tbl_count == TBL_DEPTH) begin
          flag = 1'b1;
        end else begin
          tbl_io_base[tbl_count]   = r.io_base;
          tbl_io_size[tbl_count]   = r.io_size;
          tbl_irq[tbl_count]       = r.irq;
          tbl_irq_total[tbl_count] = r.irq_total;
          tbl_name_size[tbl_count] = 5'd0;
          tbl_count++;
        end
      end
      ACT_NAME: begin
        k = KIND_LOAD;
        // no entry yet, a nul byte, or a name already at its limit
        if (tbl_count == 0 || r.nbyte == 8'h00 || tbl_name_size[top] >= NAME_SLOTS - 1) begin
          flag = 1'b1;
        end else begin
          tbl_name[top][tbl_name_size[top]] = r.nbyte;
          tbl_name_size[top]++;
        end
      end
      ACT_READ: begin
        k = KIND_READ;
        case (r.ofs)
          OFS_OP: begin
            if (walk_pos < tbl_count) begin
              sel_idx   = walk_pos[3:0];
              sel_valid = 1'b1;
              walk_pos++;
              val = CODE_ADD;
            end else begin
              sel_valid = 1'b0;
              sel_idx   = 4'd0;
              val = CODE_DONE;
            end
          end
          OFS_NAME_LEN:  val = sel ? 32'(tbl_name_size[sel_idx]) : 32'd0;
          OFS_ID:        val = sel ? {28'd0, sel_idx} : 32'd0;
          OFS_IO_BASE:   val = sel ? tbl_io_base[sel_idx] : 32'd0;
          OFS_IO_SIZE:   val = sel ? tbl_io_size[sel_idx] : 32'd0;
          OFS_IRQ:       val = sel ? tbl_irq[sel_idx] : 32'd0;
          OFS_IRQ_COUNT: val = sel ? tbl_irq_total[sel_idx] : 32'd0;
          default:       flag = 1'b1;
        endcase
      end
      ACT_WRITE: begin
        k = KIND_WDONE;
        case (r.ofs)
          OFS_OP: begin
            if (r.wdata != 32'd0) begin
              flag = 1'b1;
            end else begin
              walk_pos  = 5'd0;
              sel_valid = 1'b0;
              sel_idx   = 4'd0;
            end
          end
          OFS_NAME_HIGH: addr_hi = r.wdata;
          OFS_NAME_LOW: begin
            if (!sel) begin
              flag = 1'b1;
            end else begin
              addr_lo = r.wdata;
              len = tbl_name_size[sel_idx];
              if (len != 0) begin
                // name copy: one memory beat per byte, address wraps at 64 bits
                base = {addr_hi, addr_lo};
                for (int j = 0; j < len; j++)
                  push_result(KIND_MEM, 32'd0, base + 64'(j), tbl_name[sel_idx][j],
                              j == len - 1, 1'b0);
                return;
              end
            end
          end
          default: flag = 1'b1;
        endcase
      end
    endcase
    push_result(k, val, 64'd0, 8'd0, 1'b1, flag);
  endfunction

  // --------------------------------------------------------------------------
  // request side
  // --------------------------------------------------------------------------

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic request_t rand_request();
    request_t r;
    r.act       = action_t'($urandom_range(0, 3));
    r.ofs       = 12'($urandom);
    r.wdata     = $urandom;
    r.io_base   = $urandom;
    r.io_size   = $urandom;
    r.irq       = $urandom;
    r.irq_total = $urandom;
    r.nbyte     = 8'($urandom);
    return r;
  endfunction

  function automatic logic [11:0] pick_field();
    case ($urandom_range(0, 5))
      0:       return OFS_NAME_LEN;
      1:       return OFS_ID;
      2:       return OFS_IO_BASE;
      3:       return OFS_IO_SIZE;
      4:       return OFS_IRQ;
      default: return OFS_IRQ_COUNT;
    endcase
  endfunction

  // in_valid stays high after an accept so a zero gap never lowers and
  // raises it in the same step; any other wait lowers it first
  task automatic send_request(request_t r);
    int gap;
    gap = burst ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    action        <= r.act;
    reg_offset    <= r.ofs;
    write_data    <= r.wdata;
    dev_io_base   <= r.io_base;
    dev_io_size   <= r.io_size;
    dev_irq       <= r.irq;
    dev_irq_count <= r.irq_total;
    name_byte     <= r.nbyte;
    do @(posedge clk); while (in_stall);
    apply_request(r);
    req_count++;
  endtask

  task automatic add_entry(logic [31:0] base, logic [31:0] size, logic [31:0] irq,
                           logic [31:0] cnt);
    request_t r;
    r           = rand_request();
    r.act       = ACT_ADD;
    r.io_base   = base;
    r.io_size   = size;
    r.irq       = irq;
    r.irq_total = cnt;
    send_request(r);
  endtask

  task automatic append_name(logic [7:0] b);
    request_t r;
    r       = rand_request();
    r.act   = ACT_NAME;
    r.nbyte = b;
    send_request(r);
  endtask

  task automatic bus_read(logic [11:0] ofs);
    request_t r;
    r     = rand_request();
    r.act = ACT_READ;
    r.ofs = ofs;
    send_request(r);
  endtask

  task automatic bus_write(logic [11:0] ofs, logic [31:0] data);
    request_t r;
    r       = rand_request();
    r.act   = ACT_WRITE;
    r.ofs   = ofs;
    r.wdata = data;
    send_request(r);
  endtask

  task automatic send_noise();
    send_request(rand_request());
    noise_count++;
  endtask

  // sender holds off until every predicted beat has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_q.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // result side: random stall per beat, compare with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: beat with no request pending: kind=%0d data=%h addr=%h byte=%h",
                     $time, kind, read_data, mem_address, mem_byte);
        end else begin
          want = pending_q.pop_front();
          if (kind !== want.kind || read_data !== want.read_data ||
              mem_address !== want.mem_address || mem_byte !== want.mem_byte ||
              last !== want.last || irq_level !== want.irq_level ||
              ignored !== want.ignored) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("%0t: mismatch exp kind=%0d data=%h addr=%h byte=%h last=%b irq=%b ign=%b",
                       $time, want.kind, want.read_data, want.mem_address, want.mem_byte,
                       want.last, want.irq_level, want.ignored,
                       "\n    got kind=%0d data=%h addr=%h byte=%h last=%b irq=%b ign=%b",
                       kind, read_data, mem_address, mem_byte, last, irq_level, ignored);
          end
        end
        out_hold = burst ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (out_hold > 0) begin
        out_stall <= 1'b1;
        out_hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // everything the driver can do before any entry exists
  task automatic test_empty_table();
    bus_read(OFS_OP);                     // done answer, irq low
    append_name(8'h41);                   // no entry to append to
    bus_read(OFS_IO_BASE);                // field with nothing selected
    bus_write(OFS_NAME_LOW, 32'h1234_5678);  // name request with no selection
    bus_read(OFS_NAME_LOW);               // write-only registers do not read
    bus_read(OFS_NAME_HIGH);
    bus_read(12'hfff);                    // top of the window, unmapped
    bus_write(12'h800, 32'hdead_beef);    // unmapped write
    bus_write(OFS_OP, 32'h0000_0001);     // nonzero operation write
    bus_write(OFS_OP, 32'h8000_0000);
    bus_write(OFS_NAME_HIGH, 32'hffff_ffff);
  endtask

  // two entries at the field extremes, walked by hand
  task automatic test_entry_fields();
    add_entry(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    append_name(8'h00);                   // nul byte is dropped
    append_name(8'hff);
    append_name(8'h01);
    add_entry(32'h0, 32'h0, 32'h0, 32'h0); // stays nameless
    burst = 1'b1;
    bus_read(OFS_OP);                     // selects entry 0
    bus_read(OFS_NAME_LEN);
    bus_read(OFS_ID);
    bus_read(OFS_IO_BASE);
    bus_read(OFS_IO_SIZE);
    bus_read(OFS_IRQ);
    bus_read(OFS_IRQ_COUNT);
    burst = 1'b0;
    bus_write(OFS_NAME_LOW, 32'hffff_ffff);  // copy wraps past the top address
    bus_read(OFS_OP);                     // selects entry 1
    bus_read(OFS_ID);
    bus_write(OFS_NAME_LOW, 32'h0000_1000);  // empty name, plain write done
    bus_read(OFS_OP);                     // done, selection cleared
    bus_read(OFS_IO_BASE);
    bus_write(OFS_OP, 32'd0);             // restart raises irq again
    wait_drained();
  endtask

  // fill the table with random descriptors and names, then overflow it
  task automatic test_table_load();
    int len;
    while (tbl_count < TBL_DEPTH) begin
      add_entry(rand_word(), rand_word(), rand_word(), rand_word());
      if (tbl_count == TBL_DEPTH)
        len = NAME_SLOTS + 2;             // newest entry runs past the name limit
      else if ($urandom_range(0, 3) == 0)
        len = $urandom_range(0, NAME_SLOTS - 1);
      else
        len = $urandom_range(0, 6);
      repeat (len) begin
        if ($urandom_range(0, 15) == 0)
          append_name(8'h00);
        else
          append_name(8'($urandom_range(1, 255)));
        if ($urandom_range(0, 15) == 0)
          burst = !burst;
      end
    end
    add_entry(rand_word(), rand_word(), rand_word(), rand_word());  // table full
    burst = 1'b0;
  endtask

  // driver-style walks with random field reads and name copies, some
  // abandoned early, sprinkled with unrelated requests
  task automatic test_enumeration();
    while (req_count - noise_count < ITEMS) begin
      bus_write(OFS_OP, 32'd0);
      if ($urandom_range(0, 1) == 1)
        bus_write(OFS_NAME_HIGH, rand_word());
      while (walk_pos < tbl_count && $urandom_range(0, 19) != 0) begin
        bus_read(OFS_OP);
        repeat ($urandom_range(0, 3)) begin
          case ($urandom_range(0, 5))
            0:       bus_write(OFS_NAME_LOW, rand_word());
            1:       bus_write(OFS_NAME_HIGH, rand_word());
            default: bus_read(pick_field());
          endcase
        end
        if ($urandom_range(0, 9) == 0)
          send_noise();
        if ($urandom_range(0, 7) == 0)
          burst = !burst;
      end
      bus_read(OFS_OP);
      if ($urandom_range(0, 5) == 0)
        wait_drained();
    end
    burst = 1'b0;
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    action        = 2'd0;
    reg_offset    = 12'd0;
    write_data    = 32'd0;
    dev_io_base   = 32'd0;
    dev_io_size   = 32'd0;
    dev_irq       = 32'd0;
    dev_irq_count = 32'd0;
    name_byte     = 8'd0;
    out_stall     = 1'b0;
    tbl_count     = 5'd0;
    walk_pos      = 5'd0;
    sel_valid     = 1'b0;
    sel_idx       = 4'd0;
    addr_hi       = 32'd0;
    addr_lo       = 32'd0;
    req_count     = 0;
    noise_count   = 0;
    mismatches    = 0;
    out_hold      = 0;
    burst         = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_entry_fields();
    test_table_load();
    test_enumeration();

    // let the last beats out, then watch a little longer for strays
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_q.size() == 0)
      $display("tb_platform_device_enumerator_core: done, clean");
    else
      $display("tb_platform_device_enumerator_core: done, errors");
    $finish;
  end

endmodule
